@@ design/config_string_escaper_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the string escaper
// Immediate-implication and next-cycle-implication checks with async reset.
// ----------------------------------------------------------------------------
`ifndef CONFIG_STRING_ESCAPER_CORE_MACROS_SVH
`define CONFIG_STRING_ESCAPER_CORE_MACROS_SVH

// cons must hold in the same cycle as ante
`define CSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define CSE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/cse_pkg.sv @@
// ----------------------------------------------------------------------------
// cse_pkg
// Types, constants and helpers shared by the string escaper modules.
// ----------------------------------------------------------------------------
package cse_pkg;

	// string kinds
	localparam logic [1:0] KIND_GROUP = 2'd0;
	localparam logic [1:0] KIND_KEY   = 2'd1;
	localparam logic [1:0] KIND_VALUE = 2'd2;

	// characters
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_EQ  = 8'h3d;
	localparam logic [7:0] CH_LBR = 8'h5b;
	localparam logic [7:0] CH_BSL = 8'h5c;
	localparam logic [7:0] CH_RBR = 8'h5d;
	localparam logic [7:0] CH_N   = 8'h6e;
	localparam logic [7:0] CH_R   = 8'h72;
	localparam logic [7:0] CH_S   = 8'h73;
	localparam logic [7:0] CH_T   = 8'h74;
	localparam logic [7:0] CH_X   = 8'h78;
	localparam logic [7:0] CH_DEL = 8'h7f;

	// UTF-8 classification
	localparam logic [7:0] U8_MIN2    = 8'hc1;
	localparam logic [7:0] U8_MASK3   = 8'he0;
	localparam logic [7:0] U8_LEAD2   = 8'hc0;
	localparam logic [7:0] U8_MASK4   = 8'hf0;
	localparam logic [7:0] U8_LEAD3   = 8'he0;
	localparam logic [7:0] U8_MAX4    = 8'hf5;
	localparam logic [7:0] U8_MASK5   = 8'hf8;
	localparam logic [7:0] U8_LEAD4   = 8'hf0;
	localparam logic [7:0] U8_CMASK   = 8'hc0;
	localparam logic [7:0] U8_CONT    = 8'h80;
	localparam logic [7:0] U8_E0_MIN  = 8'ha0;
	localparam logic [7:0] U8_F0_MIN  = 8'h90;
	localparam logic [7:0] U8_F4_MAX  = 8'h8f;
	localparam logic [7:0] U8_F4      = 8'hf4;

	localparam logic [2:0] LEN2 = 3'd2;
	localparam logic [2:0] LEN3 = 3'd3;
	localparam logic [2:0] LEN4 = 3'd4;

	// command layout
	localparam int NUM_UNITS = 5;
	localparam int UNIT_IW   = $clog2(NUM_UNITS);
	localparam int UCNT_W    = $clog2(NUM_UNITS + 1);

	// command queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	typedef enum logic [1:0] {
		U_RAW,
		U_ESC,
		U_HEX
	} unit_kind_t;

	typedef struct packed {
		unit_kind_t utype;
		logic [7:0] ubyte;
	} unit_t;

	typedef struct packed {
		unit_t [NUM_UNITS-1:0] units;
		logic [UCNT_W-1:0]     n_units;
		logic                  last;
	} cmd_t;

	typedef struct packed {
		logic [7:0] byte_in;
		logic [1:0] string_kind;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_end;
	} out_item_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		return (n < 4'd10) ? {4'h3, n} : (8'h57 + {4'h0, n});
	endfunction

endpackage

@@ design/cse_front.sv @@
// ----------------------------------------------------------------------------
// cse_front
// Classifies each input byte, tracks held UTF-8 bytes and builds a command
// of up to five output units for the back end.
// ----------------------------------------------------------------------------
module cse_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            acc,
	input  cse_pkg::in_item_t item,
	output logic            cmd_push,
	output cse_pkg::cmd_t   cmd
);
	import cse_pkg::*;

	logic [7:0] pend_q [4];
	logic [1:0] pcnt_q;
	logic [2:0] exp_q;
	logic       start_q;

	logic [7:0] b;
	logic [1:0] kind;
	logic       last;
	logic       space_start;
	logic       dflt;
	logic       main_v;
	unit_t      main_u;
	logic       lead_ok;
	logic [2:0] new_exp;
	logic       bad2;
	logic       take;
	logic [2:0] hold_cnt;
	logic [2:0] exp_eff;
	logic       complete;
	logic [7:0] pend_nx [4];
	logic [UCNT_W-1:0] n_flush;
	logic       flush_hex;
	logic       flush_first;
	logic [1:0] pcnt_d;

	assign b    = item.byte_in;
	assign kind = item.string_kind;
	assign last = item.last_byte;

	// UTF-8 lead / continuation checks
	always_comb begin
		new_exp = LEN2;
		lead_ok = 1'b1;
		if (b > U8_MIN2 && (b & U8_MASK3) == U8_LEAD2)
			new_exp = LEN2;
		else if ((b & U8_MASK4) == U8_LEAD3)
			new_exp = LEN3;
		else if (b < U8_MAX4 && (b & U8_MASK5) == U8_LEAD4)
			new_exp = LEN4;
		else
			lead_ok = 1'b0;

		bad2 = (exp_q == LEN3 && pend_q[0] == U8_LEAD3 && b < U8_E0_MIN) ||
		       (exp_q == LEN4 && pend_q[0] == U8_LEAD4 && b < U8_F0_MIN) ||
		       (exp_q == LEN4 && pend_q[0] == U8_F4 && b > U8_F4_MAX);
	end

	always_comb begin
		logic [UCNT_W-1:0] idx;
		idx = '0;

		space_start = start_q && b == CH_SP && kind != KIND_GROUP;
		dflt   = 1'b0;
		main_v = 1'b0;
		main_u = '{utype: U_RAW, ubyte: b};

		if (space_start) begin
			main_v = 1'b1;
			main_u = '{utype: U_ESC, ubyte: CH_S};
		end else begin
			case (b)
				CH_LF: begin
					main_v = 1'b1;
					main_u = '{utype: U_ESC, ubyte: CH_N};
				end
				CH_TAB: begin
					main_v = 1'b1;
					main_u = '{utype: U_ESC, ubyte: CH_T};
				end
				CH_CR: begin
					main_v = 1'b1;
					main_u = '{utype: U_ESC, ubyte: CH_R};
				end
				CH_BSL: begin
					main_v = 1'b1;
					main_u = '{utype: U_ESC, ubyte: CH_BSL};
				end
				CH_EQ: begin
					main_v = 1'b1;
					main_u = '{utype: (kind != KIND_KEY) ? U_RAW : U_HEX, ubyte: b};
				end
				CH_LBR, CH_RBR: begin
					main_v = 1'b1;
					main_u = '{utype: (kind == KIND_VALUE) ? U_RAW : U_HEX, ubyte: b};
				end
				default: dflt = 1'b1;
			endcase
		end

		if (pcnt_q == 2'd0)
			take = dflt && lead_ok;
		else
			take = dflt && (b & U8_CMASK) == U8_CONT && !(pcnt_q == 2'd1 && bad2);

		if (dflt && !take) begin
			main_v = 1'b1;
			if (b < CH_SP || (kind == KIND_VALUE && b >= CH_DEL))
				main_u = '{utype: U_HEX, ubyte: b};
			else if (last && kind != KIND_GROUP && b == CH_SP)
				main_u = '{utype: U_ESC, ubyte: CH_S};   // trailing space
			else
				main_u = '{utype: U_RAW, ubyte: b};
		end

		hold_cnt = {1'b0, pcnt_q} + {2'b00, take};
		exp_eff  = (pcnt_q == 2'd0) ? new_exp : exp_q;
		complete = take && hold_cnt == exp_eff;

		for (int i = 0; i < 4; i++)
			pend_nx[i] = pend_q[i];
		if (take)
			pend_nx[pcnt_q] = b;

		// at most one flush per item: before the byte on a broken sequence,
		// after it on completion or at string end
		flush_first = 1'b0;
		flush_hex   = 1'b1;
		n_flush     = '0;
		if (dflt && !take) begin
			flush_first = 1'b1;
			n_flush     = {1'b0, pcnt_q};
		end else if (complete) begin
			flush_hex = 1'b0;
			n_flush   = hold_cnt;
		end else if (last) begin
			n_flush = hold_cnt;
		end

		pcnt_d = (complete || last || (dflt && !take)) ? 2'd0 : hold_cnt[1:0];

		for (int k = 0; k < NUM_UNITS; k++) begin
			cmd.units[k] = '{utype: U_RAW, ubyte: 8'h00};
			if (flush_first) begin
				if (UCNT_W'(k) < n_flush)
					cmd.units[k] = '{utype: U_HEX, ubyte: pend_nx[k[1:0]]};
				else if (UCNT_W'(k) == n_flush)
					cmd.units[k] = main_u;
			end else if (main_v && k == 0) begin
				cmd.units[k] = main_u;
			end else begin
				idx = UCNT_W'(k) - {{(UCNT_W-1){1'b0}}, main_v};
				if (idx < n_flush)
					cmd.units[k] = '{utype: flush_hex ? U_HEX : U_RAW,
					                 ubyte: pend_nx[idx[1:0]]};
			end
		end
		cmd.n_units = n_flush + {{(UCNT_W-1){1'b0}}, main_v};
		cmd.last    = last;
		cmd_push    = acc && cmd.n_units != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q  <= 2'd0;
			exp_q   <= 3'd0;
			start_q <= 1'b1;
		end else if (acc) begin
			pcnt_q  <= pcnt_d;
			start_q <= last;
			if (take && pcnt_q == 2'd0)
				exp_q <= new_exp;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && take)
			pend_q[pcnt_q] <= b;
	end

endmodule

@@ design/cse_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// cse_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module cse_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  cse_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output cse_pkg::cmd_t rd_data,
	output logic          empty
);
	import cse_pkg::*;

	cmd_t               mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = cnt_q == FIFO_CW'(FIFO_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem[wr_ptr_q] <= wr_data;
	end

endmodule

@@ design/cse_back.sv @@
// ----------------------------------------------------------------------------
// cse_back
// Walks the units of the head command, one output character per cycle while the
// result register is empty or popped, into a one-entry result register.
// ----------------------------------------------------------------------------
module cse_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  cse_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	input  logic               pop,
	output logic               empty,
	output cse_pkg::out_item_t result
);
	import cse_pkg::*;

	logic [UNIT_IW-1:0] unit_q;
	logic [1:0]         char_q;
	out_item_t          res_q;
	logic               rvalid_q;

	unit_t      cur;
	logic [1:0] len_m1;
	logic [7:0] ch;
	logic       last_char;
	logic       last_unit;
	logic       step;

	always_comb begin
		cur = cmd.units[unit_q];
		case (cur.utype)
			U_RAW: begin
				len_m1 = 2'd0;
				ch     = cur.ubyte;
			end
			U_ESC: begin
				len_m1 = 2'd1;
				ch     = (char_q == 2'd0) ? CH_BSL : cur.ubyte;
			end
			U_HEX: begin
				len_m1 = 2'd3;
				case (char_q)
					2'd0:    ch = CH_BSL;
					2'd1:    ch = CH_X;
					2'd2:    ch = hex_digit(cur.ubyte[7:4]);
					default: ch = hex_digit(cur.ubyte[3:0]);
				endcase
			end
			default: begin
				len_m1 = 2'd0;
				ch     = cur.ubyte;
			end
		endcase
		last_char = char_q == len_m1;
		last_unit = UCNT_W'(unit_q) == cmd.n_units - 1'b1;
		step      = cmd_valid && (!rvalid_q || pop);
		cmd_pop   = step && last_char && last_unit;
	end

	assign empty  = !rvalid_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q   <= '0;
			char_q   <= 2'd0;
			rvalid_q <= 1'b0;
		end else begin
			if (step)
				rvalid_q <= 1'b1;
			else if (pop)
				rvalid_q <= 1'b0;
			if (step) begin
				if (!last_char) begin
					char_q <= char_q + 2'd1;
				end else begin
					char_q <= 2'd0;
					unit_q <= last_unit ? '0 : unit_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q.out_byte   <= ch;
			res_q.run_last   <= last_char && last_unit;
			res_q.string_end <= last_char && last_unit && cmd.last;
		end
	end

endmodule

@@ design/config_string_escaper_core.sv @@
// ----------------------------------------------------------------------------
// config_string_escaper_core
// Escapes the bytes of configuration strings into printable text, holding
// multi-byte UTF-8 until complete.
//
//   channel  handshake        payload
//   -------  ---------------  ----------------------------------------
//   item     push / full      byte_in, string_kind, last_byte
//   result   empty / pop      out_byte, run_last, string_end
//
// An item is taken whenever the four-entry command queue has room; the
// front end classifies it and queues its units the same cycle.
// The back end sends one output byte per cycle while the result is empty or
// popped; an item gives 0 to 16 bytes: one for plain text, 2 or 4 for escapes.
// An item's first result goes through the command queue, then the result register.
// No clearing pass after reset; a stalled pop backs up through the queue.
// ----------------------------------------------------------------------------
`include "config_string_escaper_core_macros.svh"

module config_string_escaper_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  cse_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output cse_pkg::out_item_t result
);
	import cse_pkg::*;

	logic acc;
	logic cmd_push;
	cmd_t cmd_wr;
	logic cmd_full;
	logic cmd_pop;
	cmd_t cmd_rd;
	logic cmd_empty;

	assign full = cmd_full;
	assign acc  = push && !cmd_full;

	cse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.item     (item),
		.cmd_push (cmd_push),
		.cmd      (cmd_wr)
	);

	cse_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_wr),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rd),
		.empty   (cmd_empty)
	);

	cse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_rd),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

	`CSE_ASSERT_IMP(a_push_room, clk, arst_n, cmd_push, !cmd_full, "command pushed into full queue")
	`CSE_ASSERT_IMP(a_last_cmd, clk, arst_n, acc && item.last_byte, cmd_push, "string end gave no command")
	`CSE_ASSERT_IMP(a_pop_data, clk, arst_n, cmd_pop, !cmd_empty, "command popped from empty queue")
	`CSE_ASSERT_NXT(a_fill, clk, arst_n, cmd_push && cmd_empty, !cmd_empty, "queue lost a pushed command")

endmodule

@@ tb/escaper_checker.sv @@
// ----------------------------------------------------------------------------
// escaper_checker
// Watches both queue ports of the string escaper. It models the escaping and
// UTF-8 holding rules for every item taken, then compares each result popped
// against the oldest expected byte.
// ----------------------------------------------------------------------------
module escaper_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  cse_pkg::in_item_t  item,
	input  logic               empty,
	input  logic               pop,
	input  cse_pkg::out_item_t result,
	output int                 errors,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import cse_pkg::*;

	localparam int MAX_BYTES = 16;

	// partial UTF-8 character being held back
	logic [7:0] held [4];
	logic [2:0] held_cnt;
	logic [2:0] want_len;
	logic       fresh;

	logic [7:0] text[$];
	out_item_t  expected_text[$];
	int         mismatches = 0;

	function automatic void put(input logic [7:0] b);
		if (text.size() < MAX_BYTES)
			text.push_back(b);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
	endfunction

	function automatic void put_hex(input logic [7:0] b);
		put(CH_BSL);
		put(CH_X);
		put(hex_char(b[7:4]));
		put(hex_char(b[3:0]));
	endfunction

	function automatic void drop_held_escaped();
		for (int i = 0; i < held_cnt; i++)
			put_hex(held[i]);
		held_cnt = 3'd0;
	endfunction

	function automatic void drop_held_raw();
		for (int i = 0; i < held_cnt; i++)
			put(held[i]);
		held_cnt = 3'd0;
	endfunction

	function automatic bit held_complete();
		return held_cnt != 3'd0 && held_cnt == want_len;
	endfunction

	// returns 1 if the byte joins (or starts) a held character
	function automatic bit absorb(input logic [7:0] b);
		if (held_cnt == 3'd0) begin
			if (b > U8_MIN2 && (b & U8_MASK3) == U8_LEAD2)
				want_len = LEN2;
			else if ((b & U8_MASK4) == U8_LEAD3)
				want_len = LEN3;
			else if (b < U8_MAX4 && (b & U8_MASK5) == U8_LEAD4)
				want_len = LEN4;
			else
				return 1'b0;
			held[0] = b;
			held_cnt = 3'd1;
			return 1'b1;
		end
		if (held_cnt < 3'd4 && (b & U8_CMASK) == U8_CONT) begin
			// overlong and out-of-range second bytes
			if (held_cnt == 3'd1) begin
				if (want_len == LEN3 && held[0] == U8_LEAD3 && b < U8_E0_MIN)
					return 1'b0;
				if (want_len == LEN4 && held[0] == U8_LEAD4 && b < U8_F0_MIN)
					return 1'b0;
				if (want_len == LEN4 && held[0] == U8_F4 && b > U8_F4_MAX)
					return 1'b0;
			end
			held[held_cnt[1:0]] = b;
			held_cnt = held_cnt + 3'd1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic predict_escape(input in_item_t it);
		logic [7:0] b;
		logic [1:0] k;
		out_item_t  e;
		b = it.byte_in;
		k = it.string_kind;
		text.delete();
		if (fresh && b == CH_SP && k != KIND_GROUP) begin
			put(CH_BSL);
			put(CH_S);
		end else begin
			case (b)
				CH_LF: begin
					put(CH_BSL);
					put(CH_N);
				end
				CH_TAB: begin
					put(CH_BSL);
					put(CH_T);
				end
				CH_CR: begin
					put(CH_BSL);
					put(CH_R);
				end
				CH_BSL: begin
					put(CH_BSL);
					put(CH_BSL);
				end
				CH_EQ: begin
					if (k != KIND_KEY)
						put(b);
					else
						put_hex(b);
				end
				CH_LBR, CH_RBR: begin
					if (k == KIND_VALUE)
						put(b);
					else
						put_hex(b);
				end
				default: begin
					// a breaking byte is never restarted as a lead byte
					if (!absorb(b)) begin
						drop_held_escaped();
						if (b < CH_SP || (k == KIND_VALUE && b >= CH_DEL))
							put_hex(b);
						else
							put(b);
					end
				end
			endcase
			if (held_complete())
				drop_held_raw();
		end
		fresh = 1'b0;
		if (it.last_byte) begin
			if (held_complete())
				drop_held_raw();
			else
				drop_held_escaped();
			if (text.size() > 0 && text[text.size()-1] == CH_SP && k != KIND_GROUP) begin
				void'(text.pop_back());
				put(CH_BSL);
				put(CH_S);
			end
			held_cnt = 3'd0;
			fresh = 1'b1;
		end
		foreach (text[i]) begin
			e.out_byte   = text[i];
			e.run_last   = (i == text.size() - 1);
			e.string_end = it.last_byte && e.run_last;
			expected_text.push_back(e);
		end
	endtask

	task automatic check_result(input out_item_t r);
		out_item_t e;
		if (expected_text.size() == 0) begin
			$error("unexpected result: out_byte %h run_last %b string_end %b",
				r.out_byte, r.run_last, r.string_end);
			mismatches++;
		end else begin
			e = expected_text.pop_front();
			if (r.out_byte !== e.out_byte) begin
				$error("out_byte: expected %h, got %h", e.out_byte, r.out_byte);
				mismatches++;
			end
			if (r.run_last !== e.run_last) begin
				$error("run_last: expected %b, got %b", e.run_last, r.run_last);
				mismatches++;
			end
			if (r.string_end !== e.string_end) begin
				$error("string_end: expected %b, got %b", e.string_end, r.string_end);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt = 3'd0;
			want_len = 3'd0;
			fresh = 1'b1;
			expected_text.delete();
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (pop && !empty)
				check_result(result);
			if (push && !full)
				predict_escape(item);
			errors <= mismatches;
			outstanding <= expected_text.size();
		end
	end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives configuration strings of all kinds into the escaper: a directed set
// of escapes, spaces and UTF-8 corner cases, then random strings of mostly
// valid text. Push comes in bursts, pop stalls on shifting patterns; the
// checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cse_pkg::*;

	localparam logic [1:0] KIND_OTHER   = 2'd3;
	localparam int         RANDOM_ITEMS = 85;
	localparam int         CYCLE_LIMIT  = 400000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	in_item_t   item = '0;
	logic       empty;
	logic       pop = 1'b0;
	out_item_t  result;
	int         errors;
	int         outstanding;

	logic [7:0] text_bytes[$];
	int         burst_left = 0;
	int         items_sent = 0;
	int         cycles = 0;

	// receiver stall pattern
	logic [1:0]  pop_mode = 2'd0;
	int          mode_left = 0;
	logic [15:0] stall_pat = 16'hffff;

	always #10 clk = ~clk;

	config_string_escaper_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	escaper_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (mode_left == 0) begin
			pop_mode <= 2'($urandom_range(0, 2));
			mode_left <= $urandom_range(20, 120);
			stall_pat <= 16'($urandom) | 16'h0001;
		end else begin
			mode_left <= mode_left - 1;
			stall_pat <= {stall_pat[14:0], stall_pat[15]};
			case (pop_mode)
				2'd0: pop <= 1'b1;
				2'd1: pop <= stall_pat[15];
				default: pop <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	task automatic send_item(input in_item_t it);
		bit took;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		push <= 1'b1;
		item <= it;
		do begin
			@(negedge clk);
			took = !full;
			@(posedge clk);
		end while (!took);
		items_sent++;
	endtask

	// one string from text_bytes; the byte at switch_at carries alt_kind
	task automatic send_text(input logic [1:0] kind, input int switch_at,
		input logic [1:0] alt_kind);
		in_item_t it;
		for (int i = 0; i < text_bytes.size(); i++) begin
			it.byte_in     = text_bytes[i];
			it.string_kind = (i == switch_at) ? alt_kind : kind;
			it.last_byte   = (i == text_bytes.size() - 1);
			send_item(it);
		end
	endtask

	task automatic add_utf8_char(input int len);
		logic [7:0] lead;
		case (len)
			2: begin
				text_bytes.push_back(8'($urandom_range(8'hc2, 8'hdf)));
				text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
			end
			3: begin
				lead = 8'($urandom_range(8'he0, 8'hef));
				text_bytes.push_back(lead);
				if (lead == U8_LEAD3)
					text_bytes.push_back(8'($urandom_range(8'ha0, 8'hbf)));
				else
					text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
				text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
			end
			default: begin
				lead = 8'($urandom_range(8'hf0, 8'hf4));
				text_bytes.push_back(lead);
				if (lead == U8_LEAD4)
					text_bytes.push_back(8'($urandom_range(8'h90, 8'hbf)));
				else if (lead == U8_F4)
					text_bytes.push_back(8'($urandom_range(8'h80, 8'h8f)));
				else
					text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
				repeat (2) text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
			end
		endcase
	endtask

	task automatic make_text();
		int n;
		int pick;
		text_bytes.delete();
		n = $urandom_range(1, 8);
		if ($urandom_range(0, 4) == 0)
			text_bytes.push_back(CH_SP);
		while (text_bytes.size() < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				text_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
			end else if (pick < 55) begin
				case ($urandom_range(0, 7))
					0: text_bytes.push_back(CH_TAB);
					1: text_bytes.push_back(CH_LF);
					2: text_bytes.push_back(CH_CR);
					3: text_bytes.push_back(CH_BSL);
					4: text_bytes.push_back(CH_EQ);
					5: text_bytes.push_back(CH_LBR);
					6: text_bytes.push_back(CH_RBR);
					default: text_bytes.push_back(CH_SP);
				endcase
			end else if (pick < 80) begin
				add_utf8_char($urandom_range(2, 4));
			end else if (pick < 93) begin
				text_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				// truncated or broken character
				text_bytes.push_back(8'($urandom_range(8'hc2, 8'hf4)));
				repeat ($urandom_range(0, 2))
					text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
				if ($urandom_range(0, 1) == 1)
					text_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 4) == 0)
			text_bytes.push_back(CH_SP);
	endtask

	initial begin
		logic [1:0] kind;
		int         switch_at;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		text_bytes = {CH_SP, CH_BSL, CH_TAB, CH_LF, CH_CR, 8'h00, 8'hff, CH_SP};
		send_text(KIND_VALUE, -1, KIND_VALUE);
		text_bytes = {CH_SP, CH_RBR, CH_SP};
		send_text(KIND_GROUP, -1, KIND_GROUP);
		text_bytes = {CH_EQ, CH_LBR, 8'he2, 8'h82, 8'hac};
		send_text(KIND_KEY, -1, KIND_KEY);
		// overlong second byte, then a newline in a different kind mid-hold
		text_bytes = {8'he0, 8'h80, 8'hf4, CH_LF, 8'h8f, 8'h41};
		send_text(KIND_VALUE, 3, KIND_KEY);
		// unfinished lead byte at string end
		text_bytes = {CH_SP, CH_EQ, CH_LBR, CH_DEL, 8'hf0};
		send_text(KIND_OTHER, -1, KIND_OTHER);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			make_text();
			kind = ($urandom_range(0, 9) == 0) ? KIND_OTHER : 2'($urandom_range(0, 2));
			switch_at = ($urandom_range(0, 9) == 0) ?
				$urandom_range(0, text_bytes.size() - 1) : -1;
			send_text(kind, switch_at, 2'($urandom_range(0, 3)));
		end
		push <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (24) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/cse_pkg.sv
design/cse_front.sv
design/cse_cmd_fifo.sv
design/cse_back.sv
design/config_string_escaper_core.sv
tb/escaper_checker.sv
tb/tb.sv
